/* sv/alu8bd_pkg.sv */
// Shared types and constants for the pipelined ALU with Booth multiply and restoring divide.
`timescale 1ns / 1ps

package alu8bd_pkg;

  // Default datapath width
  localparam int DATA_WIDTH_DEF = 8;
  // Fixed port widths
  localparam int ACT_W  = 4;
  localparam int BYTE_W = 8;

  // Operation codes
  typedef enum logic [ACT_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_AND = 4'd2,
    OP_OR  = 4'd3,
    OP_XOR = 4'd4,
    OP_NOT = 4'd5,
    OP_SHL = 4'd6,
    OP_SHR = 4'd7,
    OP_MUL = 4'd8,
    OP_DIV = 4'd9
  } op_t;

  // Control that travels with each transaction down the cell chain.
  // flag: shift goes left (shifts), quotient gets negated (divide).
  typedef struct packed {
    logic valid;
    op_t  op;
    logic flag;
  } cell_ctrl_t;

endpackage

/* sv/alu8bd_front.sv */
// Entry decode: operand sizing, combinational ops, and initial cell chain state.
`timescale 1ns / 1ps

module alu8bd_front #(
  parameter int DATA_WIDTH = alu8bd_pkg::DATA_WIDTH_DEF,
  localparam int CW = $clog2(DATA_WIDTH)
) (
  input  logic                          start,
  input  logic [alu8bd_pkg::ACT_W-1:0]  action,
  input  logic [alu8bd_pkg::BYTE_W-1:0] operand_a,
  input  logic [alu8bd_pkg::BYTE_W-1:0] operand_b,
  output alu8bd_pkg::cell_ctrl_t        ctrl,
  output logic [DATA_WIDTH-1:0]         res,
  output logic [DATA_WIDTH-1:0]         dvs,
  output logic [DATA_WIDTH-1:0]         rem,
  output logic [DATA_WIDTH-1:0]         quo,
  output logic [DATA_WIDTH-1:0]         mcand,
  output logic [DATA_WIDTH-1:0]         mplier,
  output logic                          mprev,
  output logic [DATA_WIDTH-1:0]         acc,
  output logic [DATA_WIDTH-1:0]         shv,
  output logic [DATA_WIDTH-1:0]         smag,
  output logic [CW-1:0]                 sw,
  output logic [CW-1:0]                 sacc
);

  localparam int EW = DATA_WIDTH + alu8bd_pkg::BYTE_W;

  logic [EW-1:0]         a_ext;
  logic [EW-1:0]         b_ext;
  logic [DATA_WIDTH-1:0] a_w;
  logic [DATA_WIDTH-1:0] b_w;
  logic                  a_neg;
  logic                  b_neg;
  alu8bd_pkg::op_t       op;

  // Operands taken in their low DATA_WIDTH bits (zero-extended if wider)
  assign a_ext = {{DATA_WIDTH{1'b0}}, operand_a};
  assign b_ext = {{DATA_WIDTH{1'b0}}, operand_b};
  assign a_w   = a_ext[DATA_WIDTH-1:0];
  assign b_w   = b_ext[DATA_WIDTH-1:0];
  assign a_neg = a_w[DATA_WIDTH-1];
  assign b_neg = b_w[DATA_WIDTH-1];
  assign op    = alu8bd_pkg::op_t'(action);

  // Combinational ops and per-op flag
  always_comb begin
    res  = '0;
    ctrl.valid = start;
    ctrl.op    = op;
    ctrl.flag  = 1'b0;
    unique case (op)
      alu8bd_pkg::OP_ADD: res = a_w + b_w;
      alu8bd_pkg::OP_SUB: res = a_w - b_w;
      alu8bd_pkg::OP_AND: res = a_w & b_w;
      alu8bd_pkg::OP_OR:  res = a_w | b_w;
      alu8bd_pkg::OP_XOR: res = a_w ^ b_w;
      alu8bd_pkg::OP_NOT: res = ~a_w;
      alu8bd_pkg::OP_SHL: ctrl.flag = ~b_neg;
      alu8bd_pkg::OP_SHR: ctrl.flag = b_neg;
      alu8bd_pkg::OP_DIV: ctrl.flag = a_neg ^ b_neg;
      default: res = '0;
    endcase
  end

  // Initial chain state
  assign dvs    = b_w;
  assign rem    = '0;
  assign quo    = a_neg ? (~a_w + 1'b1) : a_w;
  assign mcand  = a_w;
  assign mplier = b_w;
  assign mprev  = 1'b0;
  assign acc    = '0;
  assign shv    = a_w;
  assign smag   = b_neg ? (~b_w + 1'b1) : b_w;
  assign sw     = CW'(1);
  assign sacc   = '0;

endmodule

/* sv/alu8bd_cell.sv */
// One chain cell: a restoring-divide iteration, a Booth step, and a shift-count mod step.
`timescale 1ns / 1ps

module alu8bd_cell #(
  parameter int DATA_WIDTH = alu8bd_pkg::DATA_WIDTH_DEF,
  localparam int CW = $clog2(DATA_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  alu8bd_pkg::cell_ctrl_t ctrl_i,
  input  logic [DATA_WIDTH-1:0]  res_i,
  input  logic [DATA_WIDTH-1:0]  dvs_i,
  input  logic [DATA_WIDTH-1:0]  rem_i,
  input  logic [DATA_WIDTH-1:0]  quo_i,
  input  logic [DATA_WIDTH-1:0]  mcand_i,
  input  logic [DATA_WIDTH-1:0]  mplier_i,
  input  logic                   mprev_i,
  input  logic [DATA_WIDTH-1:0]  acc_i,
  input  logic [DATA_WIDTH-1:0]  shv_i,
  input  logic [DATA_WIDTH-1:0]  smag_i,
  input  logic [CW-1:0]          sw_i,
  input  logic [CW-1:0]          sacc_i,
  output alu8bd_pkg::cell_ctrl_t ctrl,
  output logic [DATA_WIDTH-1:0]  res,
  output logic [DATA_WIDTH-1:0]  dvs,
  output logic [DATA_WIDTH-1:0]  rem,
  output logic [DATA_WIDTH-1:0]  quo,
  output logic [DATA_WIDTH-1:0]  mcand,
  output logic [DATA_WIDTH-1:0]  mplier,
  output logic                   mprev,
  output logic [DATA_WIDTH-1:0]  acc,
  output logic [DATA_WIDTH-1:0]  shv,
  output logic [DATA_WIDTH-1:0]  smag,
  output logic [CW-1:0]          sw,
  output logic [CW-1:0]          sacc
);

  localparam logic [CW:0] DWC = (CW+1)'(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] r_sh;
  logic [DATA_WIDTH-1:0] q_sh;
  logic [DATA_WIDTH-1:0] r_try;
  logic                  keep;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] quo_next;
  logic [DATA_WIDTH-1:0] acc_next;
  logic [CW:0]           s_sum;
  logic [CW:0]           w_dbl;
  logic [CW-1:0]         sacc_next;
  logic [CW-1:0]         sw_next;

  // Restoring divide iteration with sign-matched add/subtract
  assign r_sh  = {rem_i[DATA_WIDTH-2:0], quo_i[DATA_WIDTH-1]};
  assign q_sh  = {quo_i[DATA_WIDTH-2:0], 1'b0};
  assign r_try = (r_sh[DATA_WIDTH-1] == dvs_i[DATA_WIDTH-1]) ? (r_sh - dvs_i)
                                                             : (r_sh + dvs_i);
  assign keep     = (r_try[DATA_WIDTH-1] == r_sh[DATA_WIDTH-1]);
  assign rem_next = keep ? r_try : r_sh;
  assign quo_next = {q_sh[DATA_WIDTH-1:1], keep};

  // Radix-2 Booth step on the current multiplier bit pair
  always_comb begin
    case ({mplier_i[0], mprev_i})
      2'b10:   acc_next = acc_i - mcand_i;
      2'b01:   acc_next = acc_i + mcand_i;
      default: acc_next = acc_i;
    endcase
  end

  // Shift count mod DATA_WIDTH: add weight 2^k mod DATA_WIDTH per set bit
  assign s_sum     = {1'b0, sacc_i} + {1'b0, sw_i};
  assign sacc_next = !smag_i[0] ? sacc_i
                   : (s_sum >= DWC) ? CW'(s_sum - DWC) : s_sum[CW-1:0];
  assign w_dbl     = {sw_i, 1'b0};
  assign sw_next   = (w_dbl >= DWC) ? CW'(w_dbl - DWC) : w_dbl[CW-1:0];

  // Control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else begin
      ctrl <= ctrl_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res    <= res_i;
    dvs    <= dvs_i;
    rem    <= rem_next;
    quo    <= quo_next;
    mcand  <= {mcand_i[DATA_WIDTH-2:0], 1'b0};
    mplier <= {1'b0, mplier_i[DATA_WIDTH-1:1]};
    mprev  <= mplier_i[0];
    acc    <= acc_next;
    shv    <= shv_i;
    smag   <= {1'b0, smag_i[DATA_WIDTH-1:1]};
    sw     <= sw_next;
    sacc   <= sacc_next;
  end

endmodule

/* sv/alu8bd_out.sv */
// Output stage: selects the finished result, applies shift and quotient sign, drives the strobe.
`timescale 1ns / 1ps

module alu8bd_out #(
  parameter int DATA_WIDTH = alu8bd_pkg::DATA_WIDTH_DEF,
  localparam int CW = $clog2(DATA_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  alu8bd_pkg::cell_ctrl_t        ctrl_i,
  input  logic [DATA_WIDTH-1:0]         res_i,
  input  logic [DATA_WIDTH-1:0]         rem_i,
  input  logic [DATA_WIDTH-1:0]         quo_i,
  input  logic [DATA_WIDTH-1:0]         acc_i,
  input  logic [DATA_WIDTH-1:0]         shv_i,
  input  logic [CW-1:0]                 sacc_i,
  output logic [alu8bd_pkg::BYTE_W-1:0] result,
  output logic [alu8bd_pkg::BYTE_W-1:0] remainder,
  output logic                          done
);

  localparam int EW = DATA_WIDTH + alu8bd_pkg::BYTE_W;

  logic [DATA_WIDTH-1:0] res_w;
  logic [DATA_WIDTH-1:0] rem_w;
  logic [EW-1:0]         res_ext;
  logic [EW-1:0]         rem_ext;

  // Final select per operation
  always_comb begin
    res_w = '0;
    rem_w = '0;
    unique case (ctrl_i.op) inside
      alu8bd_pkg::OP_ADD, alu8bd_pkg::OP_SUB, alu8bd_pkg::OP_AND,
      alu8bd_pkg::OP_OR, alu8bd_pkg::OP_XOR, alu8bd_pkg::OP_NOT: res_w = res_i;
      alu8bd_pkg::OP_SHL, alu8bd_pkg::OP_SHR: begin
        res_w = ctrl_i.flag ? (shv_i << sacc_i) : (shv_i >> sacc_i);
      end
      alu8bd_pkg::OP_MUL: res_w = acc_i;
      alu8bd_pkg::OP_DIV: begin
        res_w = ctrl_i.flag ? (~quo_i + 1'b1) : quo_i;
        rem_w = rem_i;
      end
      default: res_w = '0;
    endcase
  end

  // Fit to the byte-wide ports
  assign res_ext = {{alu8bd_pkg::BYTE_W{1'b0}}, res_w};
  assign rem_ext = {{alu8bd_pkg::BYTE_W{1'b0}}, rem_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    result    <= res_ext[alu8bd_pkg::BYTE_W-1:0];
    remainder <= rem_ext[alu8bd_pkg::BYTE_W-1:0];
  end

endmodule

/* sv/alu8_booth_mul_restoring_div.sv */
// Top level: ALU with a chain of DATA_WIDTH cells for multiply, divide and shift count.
// done pulses once a taken start has passed the DATA_WIDTH cell registers and then the output register.
// Throughput: one transaction per cycle; busy is never raised.
// Every op walks the full chain of DATA_WIDTH cells, one cell per cycle, plus the output stage.
// Reset: synchronous rst clears all valid bits in the chain and the done strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module alu8_booth_mul_restoring_div #(
  parameter int DATA_WIDTH = alu8bd_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [alu8bd_pkg::ACT_W-1:0]  action,
  input  logic [alu8bd_pkg::BYTE_W-1:0] operand_a,
  input  logic [alu8bd_pkg::BYTE_W-1:0] operand_b,
  output logic [alu8bd_pkg::BYTE_W-1:0] result,
  output logic [alu8bd_pkg::BYTE_W-1:0] remainder,
  output logic                          done
);

  localparam int CW = $clog2(DATA_WIDTH);
  localparam int NC = DATA_WIDTH;

  alu8bd_pkg::cell_ctrl_t ctrl_c   [0:NC];
  logic [DATA_WIDTH-1:0]  res_c    [0:NC];
  logic [DATA_WIDTH-1:0]  dvs_c    [0:NC];
  logic [DATA_WIDTH-1:0]  rem_c    [0:NC];
  logic [DATA_WIDTH-1:0]  quo_c    [0:NC];
  logic [DATA_WIDTH-1:0]  mcand_c  [0:NC];
  logic [DATA_WIDTH-1:0]  mplier_c [0:NC];
  logic                   mprev_c  [0:NC];
  logic [DATA_WIDTH-1:0]  acc_c    [0:NC];
  logic [DATA_WIDTH-1:0]  shv_c    [0:NC];
  logic [DATA_WIDTH-1:0]  smag_c   [0:NC];
  logic [CW-1:0]          sw_c     [0:NC];
  logic [CW-1:0]          sacc_c   [0:NC];

  // Fully pipelined: always ready
  assign busy = 1'b0;

  // Entry decode
  alu8bd_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .start     (start & ~busy),
    .action    (action),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .ctrl      (ctrl_c[0]),
    .res       (res_c[0]),
    .dvs       (dvs_c[0]),
    .rem       (rem_c[0]),
    .quo       (quo_c[0]),
    .mcand     (mcand_c[0]),
    .mplier    (mplier_c[0]),
    .mprev     (mprev_c[0]),
    .acc       (acc_c[0]),
    .shv       (shv_c[0]),
    .smag      (smag_c[0]),
    .sw        (sw_c[0]),
    .sacc      (sacc_c[0])
  );

  // Cell chain, one iteration per cell
  for (genvar k = 0; k < NC; k++) begin : g_cell
    alu8bd_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl_i   (ctrl_c[k]),
      .res_i    (res_c[k]),
      .dvs_i    (dvs_c[k]),
      .rem_i    (rem_c[k]),
      .quo_i    (quo_c[k]),
      .mcand_i  (mcand_c[k]),
      .mplier_i (mplier_c[k]),
      .mprev_i  (mprev_c[k]),
      .acc_i    (acc_c[k]),
      .shv_i    (shv_c[k]),
      .smag_i   (smag_c[k]),
      .sw_i     (sw_c[k]),
      .sacc_i   (sacc_c[k]),
      .ctrl     (ctrl_c[k+1]),
      .res      (res_c[k+1]),
      .dvs      (dvs_c[k+1]),
      .rem      (rem_c[k+1]),
      .quo      (quo_c[k+1]),
      .mcand    (mcand_c[k+1]),
      .mplier   (mplier_c[k+1]),
      .mprev    (mprev_c[k+1]),
      .acc      (acc_c[k+1]),
      .shv      (shv_c[k+1]),
      .smag     (smag_c[k+1]),
      .sw       (sw_c[k+1]),
      .sacc     (sacc_c[k+1])
    );
  end

  // Output stage
  alu8bd_out #(.DATA_WIDTH(DATA_WIDTH)) u_out (
    .clk       (clk),
    .rst       (rst),
    .ctrl_i    (ctrl_c[NC]),
    .res_i     (res_c[NC]),
    .rem_i     (rem_c[NC]),
    .quo_i     (quo_c[NC]),
    .acc_i     (acc_c[NC]),
    .shv_i     (shv_c[NC]),
    .sacc_i    (sacc_c[NC]),
    .result    (result),
    .remainder (remainder),
    .done      (done)
  );

`ifndef SYNTHESIS
  // Every taken transaction comes out after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(DATA_WIDTH+1) done)
    else $error("result strobe missing after fixed latency");

  // No result without a transaction taken at the fixed latency before
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, DATA_WIDTH+1))
    else $error("result strobe without matching transaction");

  // Only divide produces a nonzero remainder
  a_rem_zero : assert property (@(posedge clk) disable iff (rst)
    (done && $past(ctrl_c[NC].op) != alu8bd_pkg::OP_DIV) |-> remainder == '0)
    else $error("nonzero remainder for non-divide op");

  // Reduced shift count stays below the word width at chain end
  a_sacc_range : assert property (@(posedge clk) disable iff (rst)
    ctrl_c[NC].valid |-> ({1'b0, sacc_c[NC]} < (CW+1)'(DATA_WIDTH)))
    else $error("shift count out of range");
`endif

endmodule
